// ----- rtl/core/assert_macros.svh -----
// assertion helpers, clocked on clk_i with reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define VVFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define VVFM_ASSERT_SAME(lbl, ante, cons, msg) \
  `VVFM_ASSERT(lbl, ante |-> cons, msg)

`define VVFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `VVFM_ASSERT(lbl, ante |=> cons, msg)

`endif

// ----- rtl/core/vvfm_pkg.sv -----
`timescale 1ns / 1ps

package vvfm_pkg;

  localparam int unsigned CHUNK_X_DEF   = 16;
  localparam int unsigned CHUNK_Y_DEF   = 64;
  localparam int unsigned CHUNK_Z_DEF   = 16;
  localparam int unsigned TYPE_BITS_DEF = 4;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned POS_X_W  = 4;
  localparam int unsigned POS_Y_W  = 6;
  localparam int unsigned POS_Z_W  = 4;
  localparam int unsigned SIDE_W   = 2;
  localparam int unsigned BLOCK_W  = 4;
  localparam int unsigned MASK_W   = 6;
  localparam int unsigned NBR_W    = 4;

  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_CELL  = 2'd0,
    OP_WR_PLANE = 2'd1,
    OP_QUERY    = 2'd2
  } opcode_e;

  localparam logic [SIDE_W-1:0] SIDE_NEG_X = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_POS_X = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_NEG_Z = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_POS_Z = 2'd3;

  typedef enum logic {
    REG_NEIGHBOR = 1'b0,
    REG_AIR      = 1'b1
  } reg_e;

  typedef struct packed {
    logic [NBR_W-1:0]   neighbor_present;
    logic [BLOCK_W-1:0] air_code;
  } cfg_t;

  typedef struct packed {
    logic chunk_we;
    logic chunk_re;
    logic edge_we;
    logic edge_re;
  } mem_ctl_t;

endpackage

// ----- rtl/core/vvfm_cfg.sv -----
`timescale 1ns / 1ps

module vvfm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vvfm_pkg::PADDR_W-1:0] paddr,
  input  logic [vvfm_pkg::PDATA_W-1:0] pwdata,
  output logic [vvfm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output vvfm_pkg::cfg_t               cfg_o
);
  import vvfm_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e sel;

  assign sel    = reg_e'(paddr[2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (sel)
        REG_NEIGHBOR: cfg_d.neighbor_present = pwdata[NBR_W-1:0];
        REG_AIR:      cfg_d.air_code         = pwdata[BLOCK_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_NEIGHBOR: prdata = PDATA_W'(cfg_q.neighbor_present);
      REG_AIR:      prdata = PDATA_W'(cfg_q.air_code);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/vvfm_store.sv -----
`timescale 1ns / 1ps

module vvfm_store #(
  parameter int unsigned CHUNK_X   = vvfm_pkg::CHUNK_X_DEF,
  parameter int unsigned CHUNK_Y   = vvfm_pkg::CHUNK_Y_DEF,
  parameter int unsigned CHUNK_Z   = vvfm_pkg::CHUNK_Z_DEF,
  parameter int unsigned TYPE_BITS = vvfm_pkg::TYPE_BITS_DEF,
  localparam int unsigned CELLS    = CHUNK_X * CHUNK_Y * CHUNK_Z,
  localparam int unsigned EDGES    = 2 * CHUNK_Y * CHUNK_Z + 2 * CHUNK_X * CHUNK_Y,
  localparam int unsigned CELL_AW  = $clog2(CELLS),
  localparam int unsigned EDGE_AW  = $clog2(EDGES)
) (
  input  logic                     clk_i,
  input  vvfm_pkg::mem_ctl_t       mem_i,
  input  logic [CELL_AW-1:0]       chunk_addr_i,
  input  logic [EDGE_AW-1:0]       edge_addr_i,
  input  logic [TYPE_BITS-1:0]     wdata_i,
  output logic [TYPE_BITS-1:0]     chunk_rdata_o,
  output logic [TYPE_BITS-1:0]     edge_rdata_o
);
  import vvfm_pkg::*;

  logic [TYPE_BITS-1:0] chunk_mem [CELLS];
  logic [TYPE_BITS-1:0] edge_mem  [EDGES];
  logic [TYPE_BITS-1:0] chunk_rdata_q;
  logic [TYPE_BITS-1:0] edge_rdata_q;

  // single port each, one access per cycle
  always_ff @(posedge clk_i) begin
    if (mem_i.chunk_we) begin
      chunk_mem[chunk_addr_i] <= wdata_i;
    end
    if (mem_i.chunk_re) begin
      chunk_rdata_q <= chunk_mem[chunk_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_i.edge_we) begin
      edge_mem[edge_addr_i] <= wdata_i;
    end
    if (mem_i.edge_re) begin
      edge_rdata_q <= edge_mem[edge_addr_i];
    end
  end

  assign chunk_rdata_o = chunk_rdata_q;
  assign edge_rdata_o  = edge_rdata_q;

endmodule

// ----- rtl/core/vvfm_ctrl.sv -----
`timescale 1ns / 1ps

module vvfm_ctrl #(
  parameter int unsigned CHUNK_X   = vvfm_pkg::CHUNK_X_DEF,
  parameter int unsigned CHUNK_Y   = vvfm_pkg::CHUNK_Y_DEF,
  parameter int unsigned CHUNK_Z   = vvfm_pkg::CHUNK_Z_DEF,
  parameter int unsigned TYPE_BITS = vvfm_pkg::TYPE_BITS_DEF,
  localparam int unsigned CELLS    = CHUNK_X * CHUNK_Y * CHUNK_Z,
  localparam int unsigned EDGES    = 2 * CHUNK_Y * CHUNK_Z + 2 * CHUNK_X * CHUNK_Y,
  localparam int unsigned CELL_AW  = $clog2(CELLS),
  localparam int unsigned EDGE_AW  = $clog2(EDGES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vvfm_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [vvfm_pkg::POS_X_W-1:0]  pos_x_i,
  input  logic [vvfm_pkg::POS_Y_W-1:0]  pos_y_i,
  input  logic [vvfm_pkg::POS_Z_W-1:0]  pos_z_i,
  input  logic [vvfm_pkg::SIDE_W-1:0]   side_i,
  input  logic [vvfm_pkg::BLOCK_W-1:0]  block_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_query_o,
  output logic [vvfm_pkg::BLOCK_W-1:0]  block_out_o,
  output logic [vvfm_pkg::MASK_W-1:0]   face_mask_o,
  input  vvfm_pkg::cfg_t                cfg_i,
  output vvfm_pkg::mem_ctl_t            mem_o,
  output logic [CELL_AW-1:0]            chunk_addr_o,
  output logic [EDGE_AW-1:0]            edge_addr_o,
  output logic [TYPE_BITS-1:0]          wdata_o,
  input  logic [TYPE_BITS-1:0]          chunk_rdata_i,
  input  logic [TYPE_BITS-1:0]          edge_rdata_i
);
  import vvfm_pkg::*;

  localparam int unsigned XPLANE = CHUNK_Y * CHUNK_Z;
  localparam int unsigned ZPLANE = CHUNK_X * CHUNK_Y;
  localparam int unsigned CMP_W  = (TYPE_BITS > BLOCK_W) ? TYPE_BITS : BLOCK_W;

  localparam logic [CELL_AW-1:0] CY_C = CELL_AW'(CHUNK_Y);
  localparam logic [CELL_AW-1:0] CZ_C = CELL_AW'(CHUNK_Z);
  localparam logic [EDGE_AW-1:0] EY_C = EDGE_AW'(CHUNK_Y);
  localparam logic [EDGE_AW-1:0] EZ_C = EDGE_AW'(CHUNK_Z);
  localparam logic [EDGE_AW-1:0] XB1  = EDGE_AW'(XPLANE);
  localparam logic [EDGE_AW-1:0] ZB0  = EDGE_AW'(2 * XPLANE);
  localparam logic [EDGE_AW-1:0] ZB1  = EDGE_AW'(2 * XPLANE + ZPLANE);

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_CTR   = 3'd1;
  localparam logic [2:0] STEP_PZ    = 3'd1;
  localparam logic [2:0] STEP_NZ    = 3'd2;
  localparam logic [2:0] STEP_NX    = 3'd3;
  localparam logic [2:0] STEP_PX    = 3'd4;
  localparam logic [2:0] STEP_NY    = 3'd5;
  localparam logic [2:0] STEP_PY    = 3'd6;
  localparam logic [2:0] STEP_LAST  = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    SRC_CHUNK,
    SRC_EDGE,
    SRC_OPEN
  } src_e;

  function automatic logic [CELL_AW-1:0] cell_idx(input logic [CELL_AW-1:0] cx,
                                                  input logic [CELL_AW-1:0] cy,
                                                  input logic [CELL_AW-1:0] cz);
    return (cx * CY_C + cy) * CZ_C + cz;
  endfunction

  function automatic logic [EDGE_AW-1:0] edge_idx(input logic [SIDE_W-1:0]  s,
                                                  input logic [EDGE_AW-1:0] ex,
                                                  input logic [EDGE_AW-1:0] ey,
                                                  input logic [EDGE_AW-1:0] ez);
    logic [EDGE_AW-1:0] idx;
    case (s)
      SIDE_NEG_X: idx = ey * EZ_C + ez;
      SIDE_POS_X: idx = XB1 + ey * EZ_C + ez;
      SIDE_NEG_Z: idx = ZB0 + ex * EY_C + ey;
      SIDE_POS_Z: idx = ZB1 + ex * EY_C + ey;
      default:    idx = '0;
    endcase
    return idx;
  endfunction

  state_e               state_q, state_d;
  logic [2:0]           step_q, step_d;
  src_e                 src_q, src_d;
  logic [POS_X_W-1:0]   x_q, x_d;
  logic [POS_Y_W-1:0]   y_q, y_d;
  logic [POS_Z_W-1:0]   z_q, z_d;
  logic                 isq_q, isq_d;
  logic [TYPE_BITS-1:0] blk_q, blk_d;
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_isq_q, out_isq_d;
  logic [BLOCK_W-1:0]   out_blk_q, out_blk_d;
  logic [MASK_W-1:0]    out_mask_q, out_mask_d;

  logic [POS_X_W:0]     nx;
  logic [POS_Y_W:0]     ny;
  logic [POS_Z_W:0]     nz;
  logic [SIDE_W-1:0]    nside;
  src_e                 step_src;
  logic                 face_open;
  logic                 blk_air;
  logic                 cell_ok;
  logic                 plane_ok;
  logic [CMP_W-1:0]     blk_ext;

  assign blk_ext = CMP_W'(block_in_i);
  assign wdata_o = blk_ext[TYPE_BITS-1:0];

  assign cell_ok  = (32'(pos_x_i) < CHUNK_X) && (32'(pos_y_i) < CHUNK_Y) &&
                    (32'(pos_z_i) < CHUNK_Z);
  assign plane_ok = (side_i == SIDE_NEG_X || side_i == SIDE_POS_X) ?
                    ((32'(pos_y_i) < CHUNK_Y) && (32'(pos_z_i) < CHUNK_Z)) :
                    ((32'(pos_x_i) < CHUNK_X) && (32'(pos_y_i) < CHUNK_Y));

  assign blk_air   = CMP_W'(blk_q) == CMP_W'(cfg_i.air_code);
  assign face_open = (src_q == SRC_OPEN) ||
                     ((src_q == SRC_EDGE) ?
                      (CMP_W'(edge_rdata_i) == CMP_W'(cfg_i.air_code)) :
                      (CMP_W'(chunk_rdata_i) == CMP_W'(cfg_i.air_code)));

  // neighbor selection for the read issued in this step
  always_comb begin
    nx       = (POS_X_W + 1)'(x_q);
    ny       = (POS_Y_W + 1)'(y_q);
    nz       = (POS_Z_W + 1)'(z_q);
    nside    = SIDE_NEG_X;
    step_src = SRC_CHUNK;
    case (step_q)
      STEP_PZ: begin
        if (32'(z_q) == CHUNK_Z - 1) begin
          nside    = SIDE_POS_Z;
          step_src = cfg_i.neighbor_present[3] ? SRC_EDGE : SRC_OPEN;
        end else begin
          nz = (POS_Z_W + 1)'(z_q) + 1'b1;
        end
      end
      STEP_NZ: begin
        if (z_q == '0) begin
          nside    = SIDE_NEG_Z;
          step_src = cfg_i.neighbor_present[2] ? SRC_EDGE : SRC_OPEN;
        end else begin
          nz = (POS_Z_W + 1)'(z_q) - 1'b1;
        end
      end
      STEP_NX: begin
        if (x_q == '0) begin
          nside    = SIDE_NEG_X;
          step_src = cfg_i.neighbor_present[0] ? SRC_EDGE : SRC_OPEN;
        end else begin
          nx = (POS_X_W + 1)'(x_q) - 1'b1;
        end
      end
      STEP_PX: begin
        if (32'(x_q) == CHUNK_X - 1) begin
          nside    = SIDE_POS_X;
          step_src = cfg_i.neighbor_present[1] ? SRC_EDGE : SRC_OPEN;
        end else begin
          nx = (POS_X_W + 1)'(x_q) + 1'b1;
        end
      end
      STEP_NY: begin
        if (y_q == '0) begin
          step_src = SRC_OPEN;
        end else begin
          ny = (POS_Y_W + 1)'(y_q) - 1'b1;
        end
      end
      STEP_PY: begin
        if (32'(y_q) == CHUNK_Y - 1) begin
          step_src = SRC_OPEN;
        end else begin
          ny = (POS_Y_W + 1)'(y_q) + 1'b1;
        end
      end
      default: step_src = SRC_CHUNK;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    src_d       = src_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    isq_d       = isq_q;
    blk_d       = blk_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    out_isq_d   = out_isq_q;
    out_blk_d   = out_blk_q;
    out_mask_d  = out_mask_q;
    mem_o       = '0;
    chunk_addr_o = cell_idx(CELL_AW'(pos_x_i), CELL_AW'(pos_y_i), CELL_AW'(pos_z_i));
    edge_addr_o  = edge_idx(side_i, EDGE_AW'(pos_x_i), EDGE_AW'(pos_y_i),
                            EDGE_AW'(pos_z_i));

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d    = pos_x_i;
          y_d    = pos_y_i;
          z_d    = pos_z_i;
          blk_d  = '0;
          mask_d = '0;
          case (opcode_e'(opcode_i))
            OP_WR_CELL: begin
              mem_o.chunk_we = cell_ok;
              isq_d          = 1'b0;
              state_d        = S_FIN;
            end
            OP_WR_PLANE: begin
              mem_o.edge_we = plane_ok;
              isq_d         = 1'b0;
              state_d       = S_FIN;
            end
            OP_QUERY: begin
              isq_d = 1'b1;
              if (cell_ok) begin
                step_d  = STEP_FIRST;
                state_d = S_READ;
              end else begin
                state_d = S_FIN;
              end
            end
            default: begin
              isq_d   = 1'b0;
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_READ: begin
        chunk_addr_o = cell_idx(CELL_AW'(nx), CELL_AW'(ny), CELL_AW'(nz));
        edge_addr_o  = edge_idx(nside, EDGE_AW'(x_q), EDGE_AW'(y_q), EDGE_AW'(z_q));
        if (step_q != STEP_LAST) begin
          mem_o.chunk_re = (step_src == SRC_CHUNK);
          mem_o.edge_re  = (step_src == SRC_EDGE);
          src_d          = step_src;
        end
        // data of the previous step is on the read port now
        if (step_q == STEP_CTR) begin
          blk_d = chunk_rdata_i;
        end else if (step_q != STEP_FIRST) begin
          mask_d[step_q - 3'd2] = face_open;
        end
        if (step_q == STEP_LAST) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_isq_d   = isq_q;
          out_blk_d   = BLOCK_W'(blk_q);
          out_mask_d  = blk_air ? '0 : mask_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_FIRST;
      src_q       <= SRC_OPEN;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      isq_q       <= 1'b0;
      blk_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      out_isq_q   <= 1'b0;
      out_blk_q   <= '0;
      out_mask_q  <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      src_q       <= src_d;
      x_q         <= x_d;
      y_q         <= y_d;
      z_q         <= z_d;
      isq_q       <= isq_d;
      blk_q       <= blk_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      out_isq_q   <= out_isq_d;
      out_blk_q   <= out_blk_d;
      out_mask_q  <= out_mask_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_query_o  = out_isq_q;
  assign block_out_o = out_blk_q;
  assign face_mask_o = out_mask_q;

endmodule

// ----- rtl/core/voxel_visible_face_mask.sv -----
`timescale 1ns / 1ps
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   opcode, pos_x, pos_y, pos_z, side, block_in
// out      output     out_valid_o / out_stall_i is_query, block_out, face_mask
// cfg      input      apb psel/penable/pwrite   neighbor_present @0x0, air_code @0x4
//
// write transaction: S_FIN loads the result register, then S_IDLE takes the next accept;
//   the write hits the store at accept when the position is in range
// query transaction: S_READ walks STEP_FIRST to STEP_LAST, then S_FIN (out of range: S_FIN only);
//   one read per cycle for the center cell and its six neighbors on single-port
//   memories, STEP_LAST for the last read data and S_FIN to load the result register
// reset clears control and configuration only; the stores start undefined
// in_stall_o is high while a transaction is in flight; a finished result waits
//   for the result register as long as out_stall_i holds the previous one

module voxel_visible_face_mask #(
  parameter int unsigned CHUNK_X   = vvfm_pkg::CHUNK_X_DEF,
  parameter int unsigned CHUNK_Y   = vvfm_pkg::CHUNK_Y_DEF,
  parameter int unsigned CHUNK_Z   = vvfm_pkg::CHUNK_Z_DEF,
  parameter int unsigned TYPE_BITS = vvfm_pkg::TYPE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vvfm_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [vvfm_pkg::POS_X_W-1:0]  pos_x_i,
  input  logic [vvfm_pkg::POS_Y_W-1:0]  pos_y_i,
  input  logic [vvfm_pkg::POS_Z_W-1:0]  pos_z_i,
  input  logic [vvfm_pkg::SIDE_W-1:0]   side_i,
  input  logic [vvfm_pkg::BLOCK_W-1:0]  block_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_query_o,
  output logic [vvfm_pkg::BLOCK_W-1:0]  block_out_o,
  output logic [vvfm_pkg::MASK_W-1:0]   face_mask_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vvfm_pkg::PADDR_W-1:0]  paddr,
  input  logic [vvfm_pkg::PDATA_W-1:0]  pwdata,
  output logic [vvfm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import vvfm_pkg::*;

  localparam int unsigned CELLS   = CHUNK_X * CHUNK_Y * CHUNK_Z;
  localparam int unsigned EDGES   = 2 * CHUNK_Y * CHUNK_Z + 2 * CHUNK_X * CHUNK_Y;
  localparam int unsigned CELL_AW = $clog2(CELLS);
  localparam int unsigned EDGE_AW = $clog2(EDGES);

  cfg_t                 cfg;
  mem_ctl_t             mem_ctl;
  logic [CELL_AW-1:0]   chunk_addr;
  logic [EDGE_AW-1:0]   edge_addr;
  logic [TYPE_BITS-1:0] wdata;
  logic [TYPE_BITS-1:0] chunk_rdata;
  logic [TYPE_BITS-1:0] edge_rdata;

  vvfm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vvfm_store #(
    .CHUNK_X   (CHUNK_X),
    .CHUNK_Y   (CHUNK_Y),
    .CHUNK_Z   (CHUNK_Z),
    .TYPE_BITS (TYPE_BITS)
  ) u_store (
    .clk_i         (clk_i),
    .mem_i         (mem_ctl),
    .chunk_addr_i  (chunk_addr),
    .edge_addr_i   (edge_addr),
    .wdata_i       (wdata),
    .chunk_rdata_o (chunk_rdata),
    .edge_rdata_o  (edge_rdata)
  );

  vvfm_ctrl #(
    .CHUNK_X   (CHUNK_X),
    .CHUNK_Y   (CHUNK_Y),
    .CHUNK_Z   (CHUNK_Z),
    .TYPE_BITS (TYPE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .side_i        (side_i),
    .block_in_i    (block_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_query_o    (is_query_o),
    .block_out_o   (block_out_o),
    .face_mask_o   (face_mask_o),
    .cfg_i         (cfg),
    .mem_o         (mem_ctl),
    .chunk_addr_o  (chunk_addr),
    .edge_addr_o   (edge_addr),
    .wdata_o       (wdata),
    .chunk_rdata_i (chunk_rdata),
    .edge_rdata_i  (edge_rdata)
  );

endmodule

// ----- rtl/core/vvfm_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vvfm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          is_query_o,
  input logic [vvfm_pkg::BLOCK_W-1:0]  block_out_o,
  input logic [vvfm_pkg::MASK_W-1:0]   face_mask_o
);
  import vvfm_pkg::*;

  `VVFM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(is_query_o) && $stable(block_out_o) && $stable(face_mask_o), "stalled result changed")

  `VVFM_ASSERT_SAME(a_ack_zero, out_valid_o && !is_query_o, block_out_o == '0 && face_mask_o == '0, "write acknowledge carries data")

  `VVFM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "second transaction taken while one is in flight")

  `VVFM_ASSERT_NEXT(a_no_bypass, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result appeared in the cycle after accept")

endmodule

bind voxel_visible_face_mask vvfm_checker u_vvfm_checker (.*);
